// ===== hdl/lsd_radix_sort_decimal_keys_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LSD_RADIX_SORT_DECIMAL_KEYS_DEFINES_SVH
`define LSD_RADIX_SORT_DECIMAL_KEYS_DEFINES_SVH

// Check cons in the same cycle as ante.
`define LSDRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define LSDRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lsdrs_pkg.sv =====
`default_nettype none
package lsdrs_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int RADIX_DEF       = 10;
    localparam int KEY_W           = 31;
    localparam int POS_W           = 6;

    // controller to datapath
    typedef struct packed {
        logic load;      // take one record
        logic check;     // clear histogram and sweep index
        logic rd;        // read the record at the sweep index
        logic mul;       // reciprocal multiply
        logic mul_max;   // multiply operand is the largest key
        logic hist_inc;  // count one digit
        logic prefix;    // one prefix-sum step
        logic scatter;   // place one record
        logic max_upd;   // next digit of largest key, swap banks
        logic emit;      // load the result register
        logic finish;    // drop the set
    } lsdrs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_rec;
        logic largest_zero;
        logic prefix_last;
        logic out_busy;
    } lsdrs_sts_t;

endpackage
`default_nettype wire

// ===== hdl/lsd_radix_sort_decimal_keys.sv =====
// Stable LSD radix sort of up to MAX_RECORDS keys in base RADIX. Records
// enter one a cycle; the one flagged final_record closes the set (records
// beyond MAX_RECORDS are dropped, but their final flag still closes it).
// While sorting and emitting, record_stall is high. For each digit of the
// largest key, lowest first, the sequencer runs a check cycle, a histogram
// sweep (per record: memory read, reciprocal multiply, count), a prefix
// sum over the RADIX digit counts, a scatter sweep into the other memory
// bank (per record: read, multiply, write) and a step that drops one digit
// from the largest key and swaps banks. A closing check cycle starts
// emission, which reads each result and holds it while the output stalls.
// The shared multiplier and the single read port of each bank mean a sweep
// takes a new record only once it is through with the last. A largest key
// of 0 skips sorting. Results leave in ascending order with their arrival
// index, run_end on the last. The result register lets the next set load
// while the last result waits.
`default_nettype none
module lsd_radix_sort_decimal_keys import lsdrs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int RADIX       = RADIX_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             record_valid,
    output logic                  record_stall,
    input  wire logic [KEY_W-1:0] record_key,
    input  wire logic             final_record,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [KEY_W-1:0]      sorted_key,
    output logic [POS_W-1:0]      source_position,
    output logic                  run_end
);

    lsdrs_cmd_t cmd;
    lsdrs_sts_t sts;

    // sequence the load, pass and emission steps
    lsdrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_valid (record_valid),
        .final_record (final_record),
        .record_stall (record_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // hold the record banks, counters and the reciprocal divider
    lsdrs_dpath #(
        .MAX_RECORDS (MAX_RECORDS),
        .RADIX       (RADIX)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .record_key      (record_key),
        .cmd             (cmd),
        .sts             (sts),
        .sorted_key      (sorted_key),
        .source_position (source_position),
        .run_end         (run_end),
        .result_valid    (result_valid),
        .result_stall    (result_stall)
    );

endmodule
`default_nettype wire

// ===== hdl/lsdrs_ctrl.sv =====
`default_nettype none
module lsdrs_ctrl import lsdrs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       record_valid,
    input  wire logic       final_record,
    output logic            record_stall,
    input  wire lsdrs_sts_t sts,
    output lsdrs_cmd_t      cmd
);

    typedef enum logic [12:0] {
        S_LOAD   = 13'b0000000000001,
        S_CHECK  = 13'b0000000000010,
        S_H_RD   = 13'b0000000000100,
        S_H_MUL  = 13'b0000000001000,
        S_H_ACC  = 13'b0000000010000,
        S_PREFIX = 13'b0000000100000,
        S_S_RD   = 13'b0000001000000,
        S_S_MUL  = 13'b0000010000000,
        S_S_WR   = 13'b0000100000000,
        S_M_MUL  = 13'b0001000000000,
        S_M_UPD  = 13'b0010000000000,
        S_E_RD   = 13'b0100000000000,
        S_E_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        record_stall = 1'b1;
        case (state_reg)
            S_LOAD:
            begin
                record_stall = 1'b0;
                cmd.load     = record_valid;
                if (record_valid && final_record)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.largest_zero ? S_E_RD : S_H_RD;
            end
            S_H_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_H_MUL;
            end
            S_H_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_H_ACC;
            end
            S_H_ACC:
            begin
                cmd.hist_inc = 1'b1;
                state_next   = sts.last_rec ? S_PREFIX : S_H_RD;
            end
            S_PREFIX:
            begin
                cmd.prefix = 1'b1;
                if (sts.prefix_last)
                    state_next = S_S_RD;
            end
            S_S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_S_MUL;
            end
            S_S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_S_WR;
            end
            S_S_WR:
            begin
                cmd.scatter = 1'b1;
                state_next  = sts.last_rec ? S_M_MUL : S_S_RD;
            end
            S_M_MUL:
            begin
                cmd.mul     = 1'b1;
                cmd.mul_max = 1'b1;
                state_next  = S_M_UPD;
            end
            S_M_UPD:
            begin
                cmd.max_upd = 1'b1;
                state_next  = S_CHECK;
            end
            S_E_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    cmd.finish = sts.last_rec;
                    state_next = sts.last_rec ? S_LOAD : S_E_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/lsdrs_dpath.sv =====
`default_nettype none
module lsdrs_dpath import lsdrs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int RADIX       = RADIX_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [KEY_W-1:0] record_key,
    input  wire lsdrs_cmd_t       cmd,
    output lsdrs_sts_t            sts,
    output logic [KEY_W-1:0]      sorted_key,
    output logic [POS_W-1:0]      source_position,
    output logic                  run_end,
    output logic                  result_valid,
    input  wire logic             result_stall
);

    localparam int IDX_W  = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int DIG_W  = $clog2(RADIX);
    localparam int WORD_W = 2 * KEY_W + IDX_W;
    localparam int SHIFT  = KEY_W + $clog2(RADIX);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(RADIX) - 64'd1) / 64'(RADIX);
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];

    // word: key, remaining quotient, arrival index
    logic [WORD_W-1:0] mem0 [MAX_RECORDS];
    logic [WORD_W-1:0] mem1 [MAX_RECORDS];
    logic [WORD_W-1:0] rd0_reg, rd1_reg, cur, wdata;
    logic              we0, we1;
    logic [IDX_W-1:0]  waddr, raddr;

    logic [CNT_W-1:0]  count_reg, idx_reg, acc_reg;
    logic [KEY_W-1:0]  largest_reg;
    logic              bank_reg;
    logic [DIG_W-1:0]  dig_idx_reg;
    logic [CNT_W-1:0]  hist_reg [RADIX];
    logic [CNT_W-1:0]  off_reg  [RADIX];
    logic [62:0]       prod_reg;

    logic [KEY_W-1:0]  cur_key, cur_rest, mul_op, quot;
    logic [IDX_W-1:0]  cur_pos;
    logic [DIG_W-1:0]  digit;
    logic              full;

    assign cur      = bank_reg ? rd1_reg : rd0_reg;
    assign cur_key  = cur[WORD_W-1 -: KEY_W];
    assign cur_rest = cur[IDX_W +: KEY_W];
    assign cur_pos  = cur[IDX_W-1:0];
    assign full     = (count_reg == CNT_W'(MAX_RECORDS));
    assign raddr    = idx_reg[IDX_W-1:0];

    assign mul_op = cmd.mul_max ? largest_reg : cur_rest;
    assign quot   = KEY_W'(prod_reg >> SHIFT);
    assign digit  = DIG_W'(cur_rest - KEY_W'(quot * KEY_W'(RADIX)));

    always_comb
    begin
        we0   = 1'b0;
        we1   = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        wdata = {record_key, record_key, count_reg[IDX_W-1:0]};
        if (cmd.load && !full)
            we0 = 1'b1;
        else if (cmd.scatter)
        begin
            we0   = bank_reg;
            we1   = !bank_reg;
            waddr = off_reg[digit][IDX_W-1:0];
            wdata = {cur_key, quot, cur_pos};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we0)
            mem0[waddr] <= wdata;
        if (cmd.rd)
            rd0_reg <= mem0[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            mem1[waddr] <= wdata;
        if (cmd.rd)
            rd1_reg <= mem1[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= {32'd0, mul_op} * {31'd0, RECIP};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            for (int k = 0; k < RADIX; k++)
                hist_reg[k] <= '0;
            acc_reg     <= '0;
            dig_idx_reg <= '0;
        end
        else if (cmd.hist_inc)
            hist_reg[digit] <= hist_reg[digit] + CNT_W'(1);
        else if (cmd.prefix)
        begin
            off_reg[dig_idx_reg] <= acc_reg;
            acc_reg              <= acc_reg + hist_reg[dig_idx_reg];
            dig_idx_reg          <= dig_idx_reg + DIG_W'(1);
        end
        else if (cmd.scatter)
            off_reg[digit] <= off_reg[digit] + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            largest_reg <= '0;
            idx_reg     <= '0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (record_key > largest_reg)
                    largest_reg <= record_key;
            end
            if (cmd.check || cmd.prefix)
                idx_reg <= '0;
            else if (cmd.hist_inc || cmd.scatter || cmd.emit)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.max_upd)
            begin
                largest_reg <= quot;
                bank_reg    <= !bank_reg;
            end
            if (cmd.finish)
            begin
                count_reg   <= '0;
                largest_reg <= '0;
                idx_reg     <= '0;
                bank_reg    <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (cmd.emit)
            result_valid <= 1'b1;
        else if (!result_stall)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sorted_key      <= cur_key;
            source_position <= POS_W'(cur_pos);
            run_end         <= sts.last_rec;
        end
    end

    assign sts.last_rec     = (CNT_W'(idx_reg + CNT_W'(1)) == count_reg);
    assign sts.largest_zero = (largest_reg == '0);
    assign sts.prefix_last  = (dig_idx_reg == DIG_W'(RADIX - 1));
    assign sts.out_busy     = result_valid && result_stall;

endmodule
`default_nettype wire

// ===== hdl/lsdrs_checker.sv =====
`default_nettype none
`include "lsd_radix_sort_decimal_keys_defines.svh"
module lsdrs_checker import lsdrs_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             record_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire logic [KEY_W-1:0] sorted_key,
    input wire logic [POS_W-1:0] source_position,
    input wire logic             run_end
);

    logic             taken;
    logic             in_run_reg;
    logic [KEY_W-1:0] prev_key_reg;

    assign taken = result_valid && !result_stall;

    // remember the last key handed out within a set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_run_reg <= 1'b0;
        else if (taken)
            in_run_reg <= !run_end;
    end

    always_ff @(posedge clk)
    begin
        if (taken)
            prev_key_reg <= sorted_key;
    end

    `LSDRS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(sorted_key) && $stable(source_position) && $stable(run_end),
        "stalled result changed")

    `LSDRS_ASSERT_SAME(a_input_closed, result_valid && !run_end, record_stall,
        "record taken while a set is being emitted")

    `LSDRS_ASSERT_SAME(a_ascending, taken && in_run_reg, sorted_key >= prev_key_reg,
        "keys not ascending")

endmodule

bind lsd_radix_sort_decimal_keys lsdrs_checker u_lsdrs_checker (.*);
`default_nettype wire
